// ===== src/rvs_pkg.sv =====
// ----------------------------------------------------------------------------
// rvs_pkg
// Shared types, opcodes, status codes and helpers for the RV64I step core.
// ----------------------------------------------------------------------------
`default_nettype none

package rvs_pkg;

  localparam int MEM_BYTES_DEF = 131072;

  // Major opcodes.
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_IMMW   = 7'h1B;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_REGW   = 7'h3B;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  // Register numbers used by the exit call.
  localparam logic [4:0] REG_A7 = 5'd17;
  localparam logic [4:0] REG_A0 = 5'd10;
  localparam logic [63:0] EXIT_CALL = 64'd93;

  // Result status codes.
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_HALT    = 3'd1;
  localparam logic [2:0] STAT_BADPC   = 3'd2;
  localparam logic [2:0] STAT_UNKNOWN = 3'd3;
  localparam logic [2:0] STAT_REJECT  = 3'd4;

  // Access size codes (log2 of the byte count).
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [16:0] load_address;
    logic [7:0]  load_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [63:0]        pc_after;
    logic               is_halted;
    logic signed [31:0] exit_value;
    logic               reg_written;
    logic [4:0]         reg_index;
    logic [63:0]        reg_value;
    logic [31:0]        tick_total;
  } out_item_t;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [1:0]  size;
    logic [63:0] addr;
  } mem_req_t;

  typedef struct packed {
    logic        we;
    logic [4:0]  addr;
    logic [63:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic        unknown;
    logic        halt;
    logic        exit_call;
    logic        is_load;
    logic        is_store;
    logic [1:0]  msize;
    logic        wr_en;
    logic [4:0]  rd;
    logic [63:0] value;
    logic [63:0] next_pc;
    logic [63:0] mem_addr;
  } exec_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_MEM,
    ST_DONE
  } state_t;

  // Extends load data according to funct3; data above the access is zero.
  function automatic logic [63:0] load_ext(input logic [2:0] f3, input logic [63:0] d);
    logic [63:0] r;
    case (f3)
      3'd0:    r = {{56{d[7]}}, d[7:0]};
      3'd1:    r = {{48{d[15]}}, d[15:0]};
      3'd2:    r = {{32{d[31]}}, d[31:0]};
      3'd3:    r = d;
      3'd4:    r = {56'd0, d[7:0]};
      3'd5:    r = {48'd0, d[15:0]};
      3'd6:    r = {32'd0, d[31:0]};
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/rvs_ram.sv =====
// ----------------------------------------------------------------------------
// rvs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/rvs_dmem.sv =====
// ----------------------------------------------------------------------------
// rvs_dmem
// Byte memory in eight byte-wide banks, so that any access of up to eight
// bytes at any alignment is served by all banks at once. Clears itself after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rvs_dmem #(
  parameter int MEM_BYTES = rvs_pkg::MEM_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rvs_pkg::mem_req_t req,
  input  wire logic [63:0]       wdata,
  output logic      [63:0]       rdata,
  output logic                   busy
);

  localparam int BANK_DEPTH = (MEM_BYTES + 7) / 8;
  localparam int RW = $clog2(BANK_DEPTH);
  localparam int AW = RW + 3;
  localparam logic [63:0] LIMIT = 64'(MEM_BYTES);
  localparam logic [RW-1:0] LAST_ROW = RW'(BANK_DEPTH - 1);

  logic [3:0]    nbytes;
  logic          ok;
  logic [2:0]    lo;
  logic [RW-1:0] base;

  logic          busy_r;
  logic [RW-1:0] clr_r;
  logic [2:0]    lo_q_r;
  logic [3:0]    n_q_r;
  logic          ok_q_r;
  logic [7:0]    bank_q [8];

  // An access is legal only when it lies wholly inside memory.
  always_comb begin
    nbytes = 4'd1 << req.size;
    ok     = req.addr <= (LIMIT - 64'(nbytes));
    lo     = req.addr[2:0];
    base   = req.addr[AW-1:3];
  end

  for (genvar b = 0; b < 8; b++) begin : g_bank
    localparam logic [2:0] BI = 3'(b);
    logic [2:0]    off;
    logic          touch;
    logic [RW-1:0] row;
    logic          bwe;
    logic [RW-1:0] bwa;
    logic [7:0]    bwd;

    always_comb begin
      off   = BI - lo;
      touch = {1'b0, off} < nbytes;
      row   = base + RW'(BI < lo);
      bwe   = busy_r || (req.wr && ok && touch);
      bwa   = busy_r ? clr_r : row;
      bwd   = busy_r ? 8'd0 : 8'(wdata >> {off, 3'b000});
    end

    rvs_ram #(
      .WIDTH(8),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (bwe),
      .waddr(bwa),
      .wdata(bwd),
      .re   (req.rd && !busy_r),
      .raddr(row),
      .rdata(bank_q[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      clr_r <= clr_r + RW'(1);
      if (clr_r == LAST_ROW) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      lo_q_r <= lo;
      n_q_r  <= nbytes;
      ok_q_r <= ok;
    end
  end

  // Rotate the bank outputs back into little-endian byte order.
  always_comb begin
    rdata = '0;
    for (int i = 0; i < 8; i++) begin
      if (ok_q_r && (4'(i) < n_q_r)) begin
        rdata[8*i +: 8] = bank_q[lo_q_r + 3'(i)];
      end
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

// ===== src/rvs_rf.sv =====
// ----------------------------------------------------------------------------
// rvs_rf
// 32 x 64 register file as two RAM copies for two read ports, with valid
// bits that give the reset value for entries not yet written.
// ----------------------------------------------------------------------------
`default_nettype none

module rvs_rf #(
  parameter int MEM_BYTES = rvs_pkg::MEM_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [4:0]       rs1,
  input  wire logic [4:0]       rs2,
  input  wire rvs_pkg::rf_wr_t  wr,
  output logic      [63:0]      x1,
  output logic      [63:0]      x2
);

  localparam logic [63:0] SP_RESET = 64'(MEM_BYTES - 8);
  localparam logic [4:0]  REG_SP = 5'd2;

  logic [31:0] vld_r;
  logic [4:0]  q1_idx_r;
  logic [4:0]  q2_idx_r;
  logic        q1_vld_r;
  logic        q2_vld_r;
  logic [63:0] d1;
  logic [63:0] d2;

  rvs_ram #(.WIDTH(64), .DEPTH(32)) u_port1 (
    .clk(clk), .we(wr.we), .waddr(wr.addr), .wdata(wr.data),
    .re(rd_en), .raddr(rs1), .rdata(d1)
  );

  rvs_ram #(.WIDTH(64), .DEPTH(32)) u_port2 (
    .clk(clk), .we(wr.we), .waddr(wr.addr), .wdata(wr.data),
    .re(rd_en), .raddr(rs2), .rdata(d2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.we) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q1_idx_r <= rs1;
      q2_idx_r <= rs2;
      q1_vld_r <= vld_r[rs1];
      q2_vld_r <= vld_r[rs2];
    end
  end

  assign x1 = q1_vld_r ? d1 : ((q1_idx_r == REG_SP) ? SP_RESET : 64'd0);
  assign x2 = q2_vld_r ? d2 : ((q2_idx_r == REG_SP) ? SP_RESET : 64'd0);

endmodule

`default_nettype wire

// ===== src/rvs_exec.sv =====
// ----------------------------------------------------------------------------
// rvs_exec
// Decode and execute of one instruction: ALU result, next pc, memory
// address and the flags that steer the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rvs_exec (
  input  wire logic [31:0]         instr,
  input  wire logic [63:0]         pc,
  input  wire logic [63:0]         x1,
  input  wire logic [63:0]         x2,
  output rvs_pkg::exec_res_t       res
);

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [5:0]  sh6;
  logic [4:0]  sh5;
  logic [63:0] imm_i;
  logic [63:0] imm_s;
  logic [63:0] imm_b;
  logic [63:0] imm_u;
  logic [63:0] imm_j;
  logic [63:0] pc4;
  logic [31:0] w32;
  logic        taken;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  assign op    = instr[6:0];
  assign f3    = instr[14:12];
  assign f7    = instr[31:25];
  assign sh6   = instr[25:20];
  assign sh5   = instr[24:20];
  assign imm_i = {{52{instr[31]}}, instr[31:20]};
  assign imm_s = {{52{instr[31]}}, instr[31:25], instr[11:7]};
  assign imm_b = {{51{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign imm_u = {{32{instr[31]}}, instr[31:12], 12'd0};
  assign imm_j = {{43{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign pc4   = pc + 64'd4;

  always_comb begin
    res          = '0;
    res.rd       = instr[11:7];
    res.next_pc  = pc4;
    res.mem_addr = x1 + imm_i;
    res.msize    = f3[1:0];
    taken        = 1'b0;
    w32          = '0;
    case (op)
      rvs_pkg::OP_LUI: begin
        res.wr_en = 1'b1;
        res.value = imm_u;
      end
      rvs_pkg::OP_AUIPC: begin
        res.wr_en = 1'b1;
        res.value = pc + imm_u;
      end
      rvs_pkg::OP_JAL: begin
        res.wr_en   = 1'b1;
        res.value   = pc4;
        res.next_pc = pc + imm_j;
      end
      rvs_pkg::OP_JALR: begin
        res.wr_en   = 1'b1;
        res.value   = pc4;
        res.next_pc = (x1 + imm_i) & ~64'd1;
      end
      rvs_pkg::OP_BRANCH: begin
        case (f3)
          3'd0:    taken = (x1 == x2);
          3'd1:    taken = (x1 != x2);
          3'd4:    taken = ($signed(x1) < $signed(x2));
          3'd5:    taken = !($signed(x1) < $signed(x2));
          3'd6:    taken = (x1 < x2);
          3'd7:    taken = (x1 >= x2);
          default: taken = 1'b0;
        endcase
        if (taken) begin
          res.next_pc = pc + imm_b;
        end
      end
      rvs_pkg::OP_LOAD: begin
        if (f3 != 3'd7) begin
          res.is_load = 1'b1;
          res.wr_en   = 1'b1;
        end
      end
      rvs_pkg::OP_STORE: begin
        res.mem_addr = x1 + imm_s;
        res.is_store = !f3[2];
      end
      rvs_pkg::OP_IMM: begin
        res.wr_en = 1'b1;
        case (f3)
          3'd0: res.value = x1 + imm_i;
          3'd1: res.value = x1 << sh6;
          3'd2: res.value = {63'd0, $signed(x1) < $signed(imm_i)};
          3'd3: res.value = {63'd0, x1 < imm_i};
          3'd4: res.value = x1 ^ imm_i;
          3'd6: res.value = x1 | imm_i;
          3'd7: res.value = x1 & imm_i;
          default: begin
            if (f7[6:1] == 6'h00) begin
              res.value = x1 >> sh6;
            end else if (f7[6:1] == 6'h10) begin
              res.value = $unsigned($signed(x1) >>> sh6);
            end else begin
              res.wr_en = 1'b0;
            end
          end
        endcase
      end
      rvs_pkg::OP_IMMW: begin
        res.wr_en = 1'b1;
        if (f3 == 3'd0) begin
          w32 = x1[31:0] + imm_i[31:0];
        end else if (f3 == 3'd1) begin
          w32 = x1[31:0] << sh5;
        end else if (f3 == 3'd5 && f7 == 7'h00) begin
          w32 = x1[31:0] >> sh5;
        end else if (f3 == 3'd5 && f7 == 7'h20) begin
          w32 = $unsigned($signed(x1[31:0]) >>> sh5);
        end else begin
          res.wr_en = 1'b0;
        end
        res.value = sx32(w32);
      end
      rvs_pkg::OP_REG: begin
        res.wr_en = 1'b1;
        case (f3)
          3'd0: begin
            if (f7 == 7'h00) begin
              res.value = x1 + x2;
            end else if (f7 == 7'h20) begin
              res.value = x1 - x2;
            end else begin
              res.wr_en = 1'b0;
            end
          end
          3'd1: res.value = x1 << x2[5:0];
          3'd2: res.value = {63'd0, $signed(x1) < $signed(x2)};
          3'd3: res.value = {63'd0, x1 < x2};
          3'd4: res.value = x1 ^ x2;
          3'd5: begin
            if (f7 == 7'h00) begin
              res.value = x1 >> x2[5:0];
            end else if (f7 == 7'h20) begin
              res.value = $unsigned($signed(x1) >>> x2[5:0]);
            end else begin
              res.wr_en = 1'b0;
            end
          end
          3'd6: res.value = x1 | x2;
          default: res.value = x1 & x2;
        endcase
      end
      rvs_pkg::OP_REGW: begin
        res.wr_en = 1'b1;
        if (f3 == 3'd0 && f7 == 7'h00) begin
          w32 = x1[31:0] + x2[31:0];
        end else if (f3 == 3'd0 && f7 == 7'h20) begin
          w32 = x1[31:0] - x2[31:0];
        end else if (f3 == 3'd1) begin
          w32 = x1[31:0] << x2[4:0];
        end else if (f3 == 3'd5 && f7 == 7'h00) begin
          w32 = x1[31:0] >> x2[4:0];
        end else if (f3 == 3'd5 && f7 == 7'h20) begin
          w32 = $unsigned($signed(x1[31:0]) >>> x2[4:0]);
        end else begin
          res.wr_en = 1'b0;
        end
        res.value = sx32(w32);
      end
      rvs_pkg::OP_SYSTEM: begin
        // For this opcode the sequencer reads a7 on port 1 and a0 on port 2.
        if (instr[31:20] == 12'd0) begin
          if (x1 == rvs_pkg::EXIT_CALL) begin
            res.halt      = 1'b1;
            res.exit_call = 1'b1;
          end
        end else if (instr[31:20] == 12'd1) begin
          res.halt = 1'b1;
        end
      end
      default: begin
        res.unknown = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rv64i_instruction_step_core_top.sv =====
// ----------------------------------------------------------------------------
// rv64i_instruction_step_core_top
// RV64I core that executes one instruction per step transaction, with
// byte loads into its memory through the same channel.
// ----------------------------------------------------------------------------
// Sequence: IDLE issues the fetch, FETCH the register read, then EXEC, MEM
// for a memory load only, and DONE, which fills the result register; a byte
// load or a refused step goes from IDLE straight to DONE. Steps run one at a
// time, as the fetch, the register read and the data access all go through
// memories with a registered read. Reset: synchronous, active low; then the
// byte memory is cleared, one row of eight bytes a cycle, before any input.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64i_instruction_step_core_top #(
  parameter int MEM_BYTES = rvs_pkg::MEM_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rvs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rvs_pkg::out_item_t      out_data
);

  localparam logic [63:0] LIMIT = 64'(MEM_BYTES);

  // Sequencer state.
  rvs_pkg::state_t state_r;
  rvs_pkg::state_t state_nxt;

  // One-entry input register, so a transaction is taken while another runs.
  logic              buf_vld_r;
  logic              buf_vld_nxt;
  rvs_pkg::in_item_t buf_r;
  rvs_pkg::in_item_t buf_nxt;

  // Architectural state outside the memories.
  logic [63:0] pc_r;
  logic [63:0] pc_nxt;
  logic        halted_r;
  logic        halted_nxt;
  logic [31:0] exit_r;
  logic [31:0] exit_nxt;
  logic [31:0] tick_r;
  logic [31:0] tick_nxt;
  logic [31:0] instr_r;
  logic [31:0] instr_nxt;

  // Result fields being built for the current transaction.
  logic [2:0]  res_status_r;
  logic [2:0]  res_status_nxt;
  logic        res_wr_r;
  logic        res_wr_nxt;
  logic [4:0]  res_idx_r;
  logic [4:0]  res_idx_nxt;
  logic [63:0] res_val_r;
  logic [63:0] res_val_nxt;

  // Output register.
  logic               out_vld_r;
  logic               out_vld_nxt;
  rvs_pkg::out_item_t out_r;
  rvs_pkg::out_item_t out_nxt;

  // Memory and register file connections.
  rvs_pkg::mem_req_t  mem_req;
  logic [63:0]        mem_wdata;
  logic [63:0]        mem_rdata;
  logic               mem_busy;
  logic               rf_rd_en;
  logic [4:0]         rf_rs1;
  logic [4:0]         rf_rs2;
  rvs_pkg::rf_wr_t    rf_wr;
  logic [63:0]        x1;
  logic [63:0]        x2;
  rvs_pkg::exec_res_t er;

  logic        in_acc;
  logic        take;
  logic        bad_pc;
  logic        ld_ok;
  logic        push;
  logic [63:0] ld_val;

  rvs_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mem_req),
    .wdata(mem_wdata),
    .rdata(mem_rdata),
    .busy (mem_busy)
  );

  rvs_rf #(.MEM_BYTES(MEM_BYTES)) u_rf (
    .clk  (clk),
    .rst_n(rst_n),
    .rd_en(rf_rd_en),
    .rs1  (rf_rs1),
    .rs2  (rf_rs2),
    .wr   (rf_wr),
    .x1   (x1),
    .x2   (x2)
  );

  rvs_exec u_exec (
    .instr(instr_r),
    .pc   (pc_r),
    .x1   (x1),
    .x2   (x2),
    .res  (er)
  );

  // Input side: the input register is free unless it holds a transaction,
  // and nothing is taken while the memory is being cleared.
  assign in_stall = buf_vld_r || mem_busy;
  assign in_acc   = in_valid && !in_stall;
  assign take     = (state_r == rvs_pkg::ST_IDLE) && buf_vld_r && !mem_busy;

  // A step is refused when the pc lies outside memory or is not word aligned.
  assign bad_pc = (pc_r >= LIMIT) || (pc_r[1:0] != 2'd0);
  assign ld_ok  = {47'd0, buf_r.load_address} < LIMIT;
  assign push   = !out_vld_r || !out_stall;
  assign ld_val = rvs_pkg::load_ext(instr_r[14:12], mem_rdata);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rvs_pkg::ST_IDLE: begin
        if (take) begin
          if (buf_r.kind || halted_r || bad_pc) begin
            state_nxt = rvs_pkg::ST_DONE;
          end else begin
            state_nxt = rvs_pkg::ST_FETCH;
          end
        end
      end
      rvs_pkg::ST_FETCH: begin
        state_nxt = rvs_pkg::ST_EXEC;
      end
      rvs_pkg::ST_EXEC: begin
        if (er.is_load) begin
          state_nxt = rvs_pkg::ST_MEM;
        end else begin
          state_nxt = rvs_pkg::ST_DONE;
        end
      end
      rvs_pkg::ST_MEM: begin
        state_nxt = rvs_pkg::ST_DONE;
      end
      rvs_pkg::ST_DONE: begin
        if (push) begin
          state_nxt = rvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rvs_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath control for each state.
  always_comb begin
    buf_vld_nxt    = in_acc ? 1'b1 : (take ? 1'b0 : buf_vld_r);
    buf_nxt        = in_acc ? in_data : buf_r;
    pc_nxt         = pc_r;
    halted_nxt     = halted_r;
    exit_nxt       = exit_r;
    tick_nxt       = tick_r;
    instr_nxt      = instr_r;
    res_status_nxt = res_status_r;
    res_wr_nxt     = res_wr_r;
    res_idx_nxt    = res_idx_r;
    res_val_nxt    = res_val_r;
    out_vld_nxt    = out_vld_r && out_stall;
    out_nxt        = out_r;
    mem_req        = '0;
    mem_wdata      = x2;
    rf_rd_en       = 1'b0;
    rf_rs1         = mem_rdata[19:15];
    rf_rs2         = mem_rdata[24:20];
    rf_wr          = '0;

    case (state_r)
      rvs_pkg::ST_IDLE: begin
        if (take) begin
          res_wr_nxt  = 1'b0;
          res_idx_nxt = 5'd0;
          res_val_nxt = 64'd0;
          if (buf_r.kind) begin
            // Byte load; the memory drops writes beyond its end by itself.
            mem_req.wr     = 1'b1;
            mem_req.size   = rvs_pkg::SZ_BYTE;
            mem_req.addr   = {47'd0, buf_r.load_address};
            mem_wdata      = {56'd0, buf_r.load_byte};
            res_status_nxt = ld_ok ? rvs_pkg::STAT_OK : rvs_pkg::STAT_REJECT;
          end else if (halted_r) begin
            res_status_nxt = rvs_pkg::STAT_HALT;
          end else if (bad_pc) begin
            res_status_nxt = rvs_pkg::STAT_BADPC;
          end else begin
            mem_req.rd   = 1'b1;
            mem_req.size = rvs_pkg::SZ_WORD;
            mem_req.addr = pc_r;
          end
        end
      end
      rvs_pkg::ST_FETCH: begin
        instr_nxt = mem_rdata[31:0];
        tick_nxt  = tick_r + 32'd1;
        rf_rd_en  = 1'b1;
        if (mem_rdata[6:0] == rvs_pkg::OP_SYSTEM) begin
          rf_rs1 = rvs_pkg::REG_A7;
          rf_rs2 = rvs_pkg::REG_A0;
        end
      end
      rvs_pkg::ST_EXEC: begin
        if (er.unknown) begin
          res_status_nxt = rvs_pkg::STAT_UNKNOWN;
        end else if (er.halt) begin
          halted_nxt     = 1'b1;
          res_status_nxt = rvs_pkg::STAT_HALT;
          if (er.exit_call) begin
            exit_nxt = x2[31:0];
          end
        end else if (er.is_load) begin
          mem_req.rd   = 1'b1;
          mem_req.size = er.msize;
          mem_req.addr = er.mem_addr;
        end else begin
          if (er.is_store) begin
            mem_req.wr   = 1'b1;
            mem_req.size = er.msize;
            mem_req.addr = er.mem_addr;
          end
          if (er.wr_en && (er.rd != 5'd0)) begin
            rf_wr.we    = 1'b1;
            rf_wr.addr  = er.rd;
            rf_wr.data  = er.value;
            res_wr_nxt  = 1'b1;
            res_idx_nxt = er.rd;
            res_val_nxt = er.value;
          end
          pc_nxt = er.next_pc;
          // A jump or branch onto itself stops the core.
          if (er.next_pc == pc_r) begin
            halted_nxt     = 1'b1;
            res_status_nxt = rvs_pkg::STAT_HALT;
          end else begin
            res_status_nxt = rvs_pkg::STAT_OK;
          end
        end
      end
      rvs_pkg::ST_MEM: begin
        if (instr_r[11:7] != 5'd0) begin
          rf_wr.we    = 1'b1;
          rf_wr.addr  = instr_r[11:7];
          rf_wr.data  = ld_val;
          res_wr_nxt  = 1'b1;
          res_idx_nxt = instr_r[11:7];
          res_val_nxt = ld_val;
        end
        pc_nxt         = pc_r + 64'd4;
        res_status_nxt = rvs_pkg::STAT_OK;
      end
      rvs_pkg::ST_DONE: begin
        if (push) begin
          out_vld_nxt         = 1'b1;
          out_nxt.status      = res_status_r;
          out_nxt.pc_after    = pc_r;
          out_nxt.is_halted   = halted_r;
          out_nxt.exit_value  = $signed(exit_r);
          out_nxt.reg_written = res_wr_r;
          out_nxt.reg_index   = res_idx_r;
          out_nxt.reg_value   = res_val_r;
          out_nxt.tick_total  = tick_r;
        end
      end
      default: begin
        out_vld_nxt = out_vld_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rvs_pkg::ST_IDLE;
      buf_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r      <= 64'd0;
      halted_r  <= 1'b0;
      exit_r    <= 32'd0;
      tick_r    <= 32'd0;
    end else begin
      state_r   <= state_nxt;
      buf_vld_r <= buf_vld_nxt;
      out_vld_r <= out_vld_nxt;
      pc_r      <= pc_nxt;
      halted_r  <= halted_nxt;
      exit_r    <= exit_nxt;
      tick_r    <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r        <= buf_nxt;
    instr_r      <= instr_nxt;
    res_status_r <= res_status_nxt;
    res_wr_r     <= res_wr_nxt;
    res_idx_r    <= res_idx_nxt;
    res_val_r    <= res_val_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== src/rvs_checker.sv =====
// ----------------------------------------------------------------------------
// rvs_checker
// Port-level checks on the RV64I step core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rvs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire rvs_pkg::out_item_t out_data
);

  // No result appears in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An accepted transaction fills the input register, so the next cycle stalls.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted transaction");

  // A stalled result stays and holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A halted status always comes with the halted flag.
  a_halt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == rvs_pkg::STAT_HALT) |-> out_data.is_halted)
    else $error("halted status without halted flag");

  // x0 is never reported as written, refused steps write nothing, and without
  // a register write the index and value read as zero.
  a_reg_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.reg_written ?
        ((out_data.reg_index != 5'd0) &&
         ((out_data.status == rvs_pkg::STAT_OK) ||
          (out_data.status == rvs_pkg::STAT_HALT))) :
        ((out_data.reg_index == 5'd0) && (out_data.reg_value == 64'd0))))
    else $error("bad register write report");

endmodule

bind rv64i_instruction_step_core_top rvs_checker u_rvs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire
